[hw/rtl/ptss_pkg.sv]
// ============================================================================
// ptss_pkg
// Shared types and constants of the periodic task slot scheduler: action and
// slot state codes, controller states, and the command and status bundles.
// ============================================================================
package ptss_pkg;

	// Defaults of the top-level parameters
	localparam int SLOTS_DEF     = 8;
	localparam int TIME_BITS_DEF = 32;

	// Request layout (tuser holds the action, tdata the rest)
	localparam int ACT_W        = 3;
	localparam int SLOT_FIELD_W = 8;
	localparam int FIELD_TIME_W = 32;
	localparam int SLOT_LSB     = 0;
	localparam int HDL_BIT      = 8;
	localparam int PER_LSB      = 9;
	localparam int START_LSB    = 41;
	localparam int NOW_LSB      = 73;
	localparam int IN_DATA_W    = 112;

	// Result layout (tuser holds the kind, tdata the rest)
	localparam int OUT_SLOT_W = 3;
	localparam int TS_W       = 2;
	localparam int OUT_DATA_W = 8;

	// Result kinds
	localparam logic KIND_REPLY = 1'b0;
	localparam logic KIND_FIRE  = 1'b1;

	// Query answer when no task is there
	localparam logic [TS_W-1:0] TS_NONE = 2'd0;

	typedef enum logic [ACT_W-1:0] {
		ACT_ALLOC      = 3'd0,
		ACT_DELETE     = 3'd1,
		ACT_START      = 3'd2,
		ACT_STOP       = 3'd3,
		ACT_SET_PERIOD = 3'd4,
		ACT_QUERY      = 3'd5,
		ACT_TICK       = 3'd6,
		ACT_FAIL       = 3'd7
	} act_t;

	// Slot state codes double as the query answer
	typedef enum logic [1:0] {
		ST_EMPTY    = 2'd0,
		ST_DISABLED = 2'd1,
		ST_ENABLED  = 2'd2
	} slot_st_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_EXEC,
		F_ALLOC,
		F_TICK_RD,
		F_TICK_EV,
		F_TICK_END
	} fsm_t;

	// Which result the output register loads
	typedef enum logic [1:0] {
		EM_REPLY,
		EM_FIRE_MID,
		EM_FIRE_LAST
	} emit_t;

	// Which value goes into the time table
	typedef enum logic [1:0] {
		TM_ALLOC,
		TM_SETPER,
		TM_TICK
	} tm_src_t;

	typedef struct packed {
		logic     load_req;
		logic     idx_clr;
		logic     idx_inc;
		logic     pend_clr;
		logic     pend_load;
		logic     emit;
		emit_t    emit_sel;
		logic     err;
		logic     give_idx;
		logic     give_state;
		logic     st_wr;
		logic     st_at_idx;
		slot_st_t st_val;
		logic     tm_wr;
		tm_src_t  tm_src;
	} cmd_t;

	typedef struct packed {
		act_t act;
		logic handler;
		logic in_range;
		logic present;
		logic scan_empty;
		logic scan_fire;
		logic scan_due;
		logic idx_last;
		logic pend;
		logic out_free;
	} sts_t;

endpackage

[hw/rtl/ptss_dp.sv]
// ============================================================================
// ptss_dp
// Datapath: request register, slot state table, period and due-time memories,
// scan counter, pending fire event and the output register.
// ============================================================================
module ptss_dp import ptss_pkg::*; #(
	parameter int SLOTS     = SLOTS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [ACT_W-1:0]      s_tuser,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic                  m_tuser,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	act_t                    req_act_q;
	logic [SLOT_FIELD_W-1:0] req_slot_q;
	logic                    req_hdl_q;
	logic [TIME_BITS-1:0]    req_per_q;
	logic [TIME_BITS-1:0]    req_start_q;
	logic [TIME_BITS-1:0]    req_now_q;

	slot_st_t             slot_state_q [SLOTS];
	logic [TIME_BITS-1:0] per_mem_q [SLOTS];
	logic [TIME_BITS-1:0] due_mem_q [SLOTS];
	logic [TIME_BITS-1:0] per_rd_q;
	logic [TIME_BITS-1:0] due_rd_q;

	logic [SLOT_W-1:0] idx_q;
	logic              pend_q;
	logic [SLOT_W-1:0] pend_slot_q;

	logic                  out_valid_q;
	logic                  out_kind_q;
	logic                  out_err_q;
	logic [OUT_SLOT_W-1:0] out_slot_q;
	logic [TS_W-1:0]       out_ts_q;
	logic                  out_last_q;

	logic [SLOT_W-1:0]     slot_idx;
	logic                  in_range;
	slot_st_t              cur_state;
	slot_st_t              scan_state;
	logic [SLOT_W-1:0]     st_addr;
	logic [SLOT_W-1:0]     wr_addr;
	logic [TIME_BITS-1:0]  add_b;
	logic [TIME_BITS-1:0]  due_wr;
	logic                  out_free;
	logic                  nx_kind;
	logic                  nx_err;
	logic [OUT_SLOT_W-1:0] nx_slot;
	logic [TS_W-1:0]       nx_ts;
	logic                  nx_last;

	// Capture the request; time fields wrap at TIME_BITS
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_act_q   <= act_t'(s_tuser);
			req_slot_q  <= s_tdata[SLOT_LSB +: SLOT_FIELD_W];
			req_hdl_q   <= s_tdata[HDL_BIT];
			req_per_q   <= TIME_BITS'(s_tdata[PER_LSB +: FIELD_TIME_W]);
			req_start_q <= TIME_BITS'(s_tdata[START_LSB +: FIELD_TIME_W]);
			req_now_q   <= TIME_BITS'(s_tdata[NOW_LSB +: FIELD_TIME_W]);
		end
	end

	assign slot_idx   = req_slot_q[SLOT_W-1:0];
	assign in_range   = req_slot_q < SLOT_FIELD_W'(SLOTS);
	assign cur_state  = slot_state_q[slot_idx];
	assign scan_state = slot_state_q[idx_q];

	// Slot state table, all empty after reset
	assign st_addr = cmd.st_at_idx ? idx_q : slot_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_state_q[i] <= ST_EMPTY;
			end
		end else if (cmd.st_wr) begin
			slot_state_q[st_addr] <= cmd.st_val;
		end
	end

	// Period and due-time memories: one write port, one registered read at the scan index
	assign wr_addr = (cmd.tm_src == TM_SETPER) ? slot_idx : idx_q;
	assign add_b   = (cmd.tm_src == TM_TICK) ? per_rd_q : req_per_q;
	assign due_wr  = (cmd.tm_src == TM_ALLOC) ? req_start_q : req_now_q + add_b;

	always_ff @(posedge clk) begin
		if (cmd.tm_wr && cmd.tm_src != TM_TICK) begin
			per_mem_q[wr_addr] <= req_per_q;
		end
		if (cmd.tm_wr) begin
			due_mem_q[wr_addr] <= due_wr;
		end
		per_rd_q <= per_mem_q[idx_q];
		due_rd_q <= due_mem_q[idx_q];
	end

	// Scan counter and pending fire event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			pend_q      <= 1'b0;
			pend_slot_q <= '0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + SLOT_W'(1);
			end
			if (cmd.pend_clr) begin
				pend_q <= 1'b0;
			end else if (cmd.pend_load) begin
				pend_q      <= 1'b1;
				pend_slot_q <= idx_q;
			end
		end
	end

	// Select the result to load
	always_comb begin
		nx_kind = KIND_REPLY;
		nx_err  = 1'b0;
		nx_slot = '0;
		nx_ts   = TS_NONE;
		nx_last = 1'b1;
		case (cmd.emit_sel)
			EM_REPLY: begin
				nx_err  = cmd.err;
				nx_slot = cmd.give_idx ? OUT_SLOT_W'(idx_q) : '0;
				nx_ts   = cmd.give_state ? TS_W'(cur_state) : TS_NONE;
			end
			EM_FIRE_MID: begin
				nx_kind = KIND_FIRE;
				nx_slot = OUT_SLOT_W'(pend_slot_q);
				nx_last = 1'b0;
			end
			EM_FIRE_LAST: begin
				nx_kind = KIND_FIRE;
				nx_slot = OUT_SLOT_W'(pend_slot_q);
			end
			default: begin
				nx_err = 1'b1;
			end
		endcase
	end

	// Output register: hold until taken
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q <= nx_kind;
			out_err_q  <= nx_err;
			out_slot_q <= nx_slot;
			out_ts_q   <= nx_ts;
			out_last_q <= nx_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {2'b00, out_ts_q, out_slot_q, out_err_q};
	assign m_tlast  = out_last_q;

	// Status toward the controller
	always_comb begin
		sts            = '0;
		sts.act        = req_act_q;
		sts.handler    = req_hdl_q;
		sts.in_range   = in_range;
		sts.present    = in_range && (cur_state != ST_EMPTY);
		sts.scan_empty = scan_state == ST_EMPTY;
		sts.scan_fire  = (scan_state == ST_ENABLED)
			&& ((per_rd_q == '0) || (due_rd_q < req_now_q));
		sts.scan_due   = (scan_state == ST_ENABLED) && (per_rd_q != '0)
			&& (due_rd_q < req_now_q);
		sts.idx_last   = idx_q == SLOT_W'(SLOTS - 1);
		sts.pend       = pend_q;
		sts.out_free   = out_free;
	end

endmodule

[hw/rtl/ptss_ctrl.sv]
// ============================================================================
// ptss_ctrl
// Controller: decodes the held request, steps the alloc and tick scans over
// the slots and schedules each result into the output register.
// ============================================================================
module ptss_ctrl import ptss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	fsm_t state_q;
	fsm_t state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and commands
	always_comb begin
		state_nx     = state_q;
		cmd          = '0;
		cmd.emit_sel = EM_REPLY;
		cmd.st_val   = ST_EMPTY;
		cmd.tm_src   = TM_ALLOC;
		s_tready     = 1'b0;
		case (state_q)
			F_IDLE: begin
				s_tready     = 1'b1;
				cmd.load_req = s_tvalid;
				if (s_tvalid) begin
					state_nx = F_EXEC;
				end
			end
			F_EXEC: begin
				case (sts.act)
					ACT_ALLOC: begin
						if (sts.handler) begin
							cmd.idx_clr = 1'b1;
							state_nx    = F_ALLOC;
						end else if (sts.out_free) begin
							cmd.emit = 1'b1;
							cmd.err  = 1'b1;
							state_nx = F_IDLE;
						end
					end
					ACT_TICK: begin
						cmd.idx_clr  = 1'b1;
						cmd.pend_clr = 1'b1;
						state_nx     = F_TICK_RD;
					end
					default: begin
						// Single-slot actions: update and reply together
						if (sts.out_free) begin
							cmd.emit = 1'b1;
							state_nx = F_IDLE;
							case (sts.act)
								ACT_DELETE: begin
									cmd.err    = !sts.in_range;
									cmd.st_wr  = sts.in_range;
									cmd.st_val = ST_EMPTY;
								end
								ACT_START: begin
									cmd.err    = !sts.present;
									cmd.st_wr  = sts.present;
									cmd.st_val = ST_ENABLED;
								end
								ACT_STOP, ACT_FAIL: begin
									cmd.err    = !sts.present;
									cmd.st_wr  = sts.present;
									cmd.st_val = ST_DISABLED;
								end
								ACT_SET_PERIOD: begin
									cmd.err    = !sts.present;
									cmd.tm_wr  = sts.present;
									cmd.tm_src = TM_SETPER;
								end
								ACT_QUERY: begin
									cmd.err        = !sts.present;
									cmd.give_state = sts.present;
								end
								default: begin
									cmd.err = 1'b1;
								end
							endcase
						end
					end
				endcase
			end
			F_ALLOC: begin
				// Find the first empty slot, one slot a cycle
				if (sts.scan_empty) begin
					if (sts.out_free) begin
						cmd.emit      = 1'b1;
						cmd.give_idx  = 1'b1;
						cmd.st_wr     = 1'b1;
						cmd.st_at_idx = 1'b1;
						cmd.st_val    = ST_DISABLED;
						cmd.tm_wr     = 1'b1;
						cmd.tm_src    = TM_ALLOC;
						state_nx      = F_IDLE;
					end
				end else if (sts.idx_last) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						cmd.err  = 1'b1;
						state_nx = F_IDLE;
					end
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			F_TICK_RD: begin
				state_nx = F_TICK_EV;
			end
			F_TICK_EV: begin
				// Hold while an earlier fire event cannot be handed on
				if (!(sts.scan_fire && sts.pend && !sts.out_free)) begin
					if (sts.scan_fire) begin
						cmd.pend_load = 1'b1;
						cmd.tm_wr     = sts.scan_due;
						cmd.tm_src    = TM_TICK;
						if (sts.pend) begin
							cmd.emit     = 1'b1;
							cmd.emit_sel = EM_FIRE_MID;
						end
					end
					if (sts.idx_last) begin
						state_nx = F_TICK_END;
					end else begin
						cmd.idx_inc = 1'b1;
						state_nx    = F_TICK_RD;
					end
				end
			end
			F_TICK_END: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = sts.pend ? EM_FIRE_LAST : EM_REPLY;
					state_nx     = F_IDLE;
				end
			end
			default: begin
				state_nx = F_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/periodic_task_slot_scheduler.sv]
// ============================================================================
// periodic_task_slot_scheduler
// Table of periodic task slots driven by action requests; a tick request
// scans the slots and emits one fire event per slot that is due, or a reply if none is.
// ============================================================================
//
// Channel   Dir  Handshake         tuser          tdata / tlast
// s_*       in   s_tvalid/tready   action[2:0]    slot, handler_present, period,
//                                                  start_time, now
// m_*       out  m_tvalid/tready   kind           error, slot_out, task_state;
//                                                  tlast = last result of request
//
// Sequencing: one request at a time. Alloc checks one slot a cycle; in a tick
// scan each slot needs a registered read of the period/due memories and a
// compare, fire and write-back of the due time, and a final step closes the scan.
// Reset: arst_n clears every slot to empty at once; no clearing pass.
// Stalls: a held result on m_* does not block accepting the next request; the
// scan pauses only when a new result is ready and the output register is full.
//
module periodic_task_slot_scheduler import ptss_pkg::*; #(
	parameter int SLOTS     = SLOTS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [ACT_W-1:0]      s_tuser,   // action
	input  logic [IN_DATA_W-1:0]  s_tdata,   // slot[7:0], handler_present[8], period[40:9],
	                                         // start_time[72:41], now[104:73], zeros
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic                  m_tuser,   // kind
	output logic [OUT_DATA_W-1:0] m_tdata,   // error[0], slot_out[3:1], task_state[5:4], zeros
	output logic                  m_tlast
);

	cmd_t cmd;
	sts_t sts;

	ptss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptss_dp #(
		.SLOTS     (SLOTS),
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

`ifndef NO_ASSERTIONS
	// A result is loaded only into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result loaded over a held result");

	// No result is produced while waiting for a request
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !cmd.emit && !cmd.st_wr && !cmd.tm_wr)
		else $error("activity while idle");

	// Fire events carry no error and no query answer
	a_fire_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_FIRE) |-> (m_tdata[0] == 1'b0)
			&& (m_tdata[5:4] == TS_NONE))
		else $error("fire event with reply fields set");

	// A held result does not change until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("held result changed");
`endif

endmodule
